### design/keyed_priority_task_queue_top_macros.svh
// assertion macros for the keyed priority task queue
`ifndef KEYED_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH
`define KEYED_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define KPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define KPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/kpq_pkg.sv
// shared types and constants for the keyed priority task queue
package kpq_pkg;

  localparam int DefCapacity = 64;

  localparam int InDataW  = 72;
  localparam int OutDataW = 24;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_EDIT   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_EXEC   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [15:0] tid;
    logic [15:0] uid;
    logic [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic clear_wr;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic addr_last;
    logic out_free;
  } stat_t;

endpackage

### design/kpq_ram.sv
// generic single write port ram with registered read
module kpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/kpq_ctrl.sv
// sequencer for clear pass, table scan and commit
module kpq_ctrl import kpq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_LAST   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.addr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.addr_last) state_next = S_LAST;
      end
      S_LAST: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/kpq_dp.sv
// table memory, scan trackers and result register
module kpq_dp import kpq_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [InDataW-1:0]  in_data,
  input  logic                out_ready,
  output stat_t               stat,
  output logic                out_valid,
  output logic [OutDataW-1:0] out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = $bits(entry_t);

  logic [AW-1:0] addr;
  logic          rd_vld;
  logic [AW-1:0] rd_addr;
  entry_t        rd_entry;

  logic [1:0]  req_op;
  logic [15:0] req_tid;
  logic [15:0] req_uid;
  logic [31:0] req_prio;

  logic          match_found;
  logic [AW-1:0] match_idx;
  logic [15:0]   match_uid;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          best_found;
  logic [AW-1:0] best_idx;
  logic [31:0]   best_prio;
  logic [15:0]   best_tid;
  logic [15:0]   best_uid;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [1:0]    res_status;
  logic [15:0]   res_user;

  kpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rd_entry)
  );

  assign stat.addr_last = (addr == AW'(CAPACITY - 1));
  assign stat.out_free  = !out_valid || out_ready;

  // address counter shared by the clear pass and the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      addr   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.load) begin
        addr <= '0;
      end else if (cmd.issue || cmd.clear_wr) begin
        addr <= addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= addr;
    if (cmd.load) begin
      req_op   <= in_data[1:0];
      req_tid  <= in_data[17:2];
      req_uid  <= in_data[33:18];
      req_prio <= in_data[65:34];
    end
  end

  // trackers over the scanned entries
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
      best_found  <= 1'b0;
    end else if (rd_vld) begin
      if (!match_found && rd_entry.valid && rd_entry.tid == req_tid) begin
        match_found <= 1'b1;
        match_idx   <= rd_addr;
        match_uid   <= rd_entry.uid;
      end
      if (!free_found && !rd_entry.valid) begin
        free_found <= 1'b1;
        free_idx   <= rd_addr;
      end
      if (rd_entry.valid && (!best_found || rd_entry.prio > best_prio ||
          (rd_entry.prio == best_prio && rd_entry.tid > best_tid))) begin
        best_found <= 1'b1;
        best_idx   <= rd_addr;
        best_prio  <= rd_entry.prio;
        best_tid   <= rd_entry.tid;
        best_uid   <= rd_entry.uid;
      end
    end
  end

  // clear writes and commit decision
  always_comb begin
    we         = 1'b0;
    waddr      = addr;
    wdata      = '0;
    res_status = ST_OK;
    res_user   = '0;
    if (cmd.clear_wr) begin
      we = 1'b1;
    end else if (cmd.commit) begin
      case (req_op)
        OP_ADD: begin
          wdata = '{valid: 1'b1, tid: req_tid, uid: req_uid, prio: req_prio};
          if (match_found) begin
            we    = 1'b1;
            waddr = match_idx;
          end else if (free_found) begin
            we    = 1'b1;
            waddr = free_idx;
          end else begin
            res_status = ST_FULL;
          end
        end
        OP_EDIT: begin
          wdata = '{valid: 1'b1, tid: req_tid, uid: match_uid, prio: req_prio};
          waddr = match_idx;
          if (match_found) we = 1'b1;
          else res_status = ST_MISSING;
        end
        OP_REMOVE: begin
          waddr = match_idx;
          if (match_found) we = 1'b1;
          else res_status = ST_MISSING;
        end
        default: begin
          waddr = best_idx;
          if (best_found) begin
            we       = 1'b1;
            res_user = best_uid;
          end else begin
            res_status = ST_MISSING;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {6'd0, res_user, res_status};
    end
  end

endmodule

### design/keyed_priority_task_queue_top.sv
// a result is registered after the table scan, the last state and the
// commit state, and the commit waits while the result register is full
// a new transaction is taken only after the last one commits; the table memory
// is scanned through its single read port, one entry per cycle, and the result
// register lets a finished result wait while the next scan runs; after reset
// a clearing pass empties the table, and s_axis_tready stays low until it ends
module keyed_priority_task_queue_top import kpq_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // operation[1:0], task_id[17:2], user_id[33:18], priority_req[65:34], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status[1:0], top_user[17:2], zero pad
  output logic [OutDataW-1:0] m_axis_tdata
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: clear pass, then accept, scan, commit per transaction
  kpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  // table memory with match, free slot and best entry trackers
  kpq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (s_axis_tdata),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

### design/kpq_checker.sv
// port level checks for the keyed priority task queue
`include "keyed_priority_task_queue_top_macros.svh"

module kpq_port_checker import kpq_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic [1:0]  out_status;
  logic [15:0] out_user;

  assign out_status = m_axis_tdata[1:0];
  assign out_user   = m_axis_tdata[17:2];

  `KPQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `KPQ_ASSERT_SAME(a_status_code, m_axis_tvalid, out_status != 2'd3, "bad status code")
  `KPQ_ASSERT_SAME(a_user_zero, m_axis_tvalid && out_status != ST_OK, out_user == 16'd0, "user set")
  `KPQ_ASSERT_NEXT(a_busy_after, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")

endmodule

bind keyed_priority_task_queue_top kpq_port_checker u_kpq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### test/kpq_checker.sv
// scoreboard for the keyed priority task queue: predicts and compares results
`timescale 1ns / 1ps
module kpq_checker import kpq_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  output int                  errors,
  output int                  pending,
  output int                  results_seen
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] top_user;
  } outcome_t;

  logic        tbl_valid [CAPACITY];
  logic [15:0] tbl_task  [CAPACITY];
  logic [15:0] tbl_user  [CAPACITY];
  logic [31:0] tbl_prio  [CAPACITY];
  outcome_t    outcome_q [$];

  function automatic int find_task(logic [15:0] id);
    for (int i = 0; i < CAPACITY; i++)
      if (tbl_valid[i] && tbl_task[i] == id) return i;
    return CAPACITY;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < CAPACITY; i++)
      if (!tbl_valid[i]) return i;
    return CAPACITY;
  endfunction

  task automatic predict_outcome(input logic [1:0] op, input logic [15:0] id,
                                 input logic [15:0] user, input logic [31:0] prio,
                                 output outcome_t res);
    int s;
    int best;
    res = '{status: ST_OK, top_user: 16'd0};
    case (op)
      OP_ADD: begin
        s = find_task(id);
        if (s == CAPACITY) s = find_free();
        if (s == CAPACITY) res.status = ST_FULL;
        else begin
          tbl_valid[s] = 1'b1;
          tbl_task[s]  = id;
          tbl_user[s]  = user;
          tbl_prio[s]  = prio;
        end
      end
      OP_EDIT: begin
        s = find_task(id);
        if (s == CAPACITY) res.status = ST_MISSING;
        else tbl_prio[s] = prio;
      end
      OP_REMOVE: begin
        s = find_task(id);
        if (s == CAPACITY) res.status = ST_MISSING;
        else tbl_valid[s] = 1'b0;
      end
      default: begin
        best = CAPACITY;
        for (int i = 0; i < CAPACITY; i++) begin
          if (!tbl_valid[i]) continue;
          if (best == CAPACITY || tbl_prio[i] > tbl_prio[best] ||
              (tbl_prio[i] == tbl_prio[best] && tbl_task[i] > tbl_task[best]))
            best = i;
        end
        if (best == CAPACITY) res.status = ST_MISSING;
        else begin
          res.top_user = tbl_user[best];
          tbl_valid[best] = 1'b0;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    for (int i = 0; i < CAPACITY; i++) tbl_valid[i] = 1'b0;
  end

  assign pending = outcome_q.size();

  always @(posedge clk) begin
    outcome_t res;
    outcome_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_outcome(s_axis_tdata[1:0], s_axis_tdata[17:2], s_axis_tdata[33:18],
                        s_axis_tdata[65:34], res);
        outcome_q.push_back(res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected transaction", m_axis_tdata, 0);
        end else begin
          want = outcome_q.pop_front();
          if (m_axis_tdata[1:0] != want.status)
            report_mismatch("status", m_axis_tdata[1:0], want.status);
          if (m_axis_tdata[17:2] != want.top_user)
            report_mismatch("top_user", m_axis_tdata[17:2], want.top_user);
          if (m_axis_tdata[OutDataW-1:18] != '0)
            report_mismatch("pad", m_axis_tdata[OutDataW-1:18], 0);
        end
        results_seen++;
      end
    end
  end

endmodule

### test/testbench.sv
// top of the keyed priority task queue testbench: stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import kpq_pkg::*;

  localparam int CAPACITY = DefCapacity;
  // no transaction on either channel for this many cycles means a hang
  localparam int StallLimit = 4000;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // operation[1:0], task_id[17:2], user_id[33:18], priority_req[65:34], zero pad
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // status[1:0], top_user[17:2], zero pad
  logic [OutDataW-1:0] m_axis_tdata;

  int errors;
  int pending;
  int results_seen;
  int tx_idle;     // sender idle percentage
  int rx_idle;     // receiver idle percentage
  int hold_req;    // cycles the receiver is asked to hold off
  int quiet_cycles;
  int items_sent;
  logic [15:0] id_pool [96];

  keyed_priority_task_queue_top #(.CAPACITY(CAPACITY)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  kpq_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random backpressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req > 0) begin
      m_axis_tready <= 1'b0;
      hold_req <= hold_req - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("keyed_priority_task_queue_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one transaction, with random idle cycles ahead of it
  task automatic send_op(input logic [1:0] op, input logic [15:0] id,
                         input logic [15:0] user, input logic [31:0] prio);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-66){1'b0}}, prio, user, id, op};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // one random transaction; fill_bias steers between add-heavy and drain-heavy
  task automatic send_random(input bit fill_bias);
    int r;
    logic [1:0]  op;
    logic [15:0] id;
    logic [31:0] prio;
    r = $urandom_range(99);
    if (fill_bias) op = (r < 60) ? OP_ADD : (r < 75) ? OP_EDIT : (r < 88) ? OP_REMOVE : OP_EXEC;
    else           op = (r < 20) ? OP_ADD : (r < 35) ? OP_EDIT : (r < 55) ? OP_REMOVE : OP_EXEC;
    // mostly pooled ids so edits and removes hit, sometimes any id
    id = ($urandom_range(9) == 0) ? 16'($urandom) : id_pool[$urandom_range(95)];
    // a narrow priority range now and then forces ties
    case ($urandom_range(3))
      0:       prio = $urandom_range(3);
      1:       prio = 32'hFFFF_FFFF - $urandom_range(1);
      default: prio = $urandom;
    endcase
    send_op(op, id, 16'($urandom), prio);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    hold_req = 0;
    tx_idle = 0;
    rx_idle = 0;
    items_sent = 0;
    for (int i = 0; i < 96; i++) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, absent ids, extremes, replace, ties
    send_op(OP_EXEC,   16'h0005, 16'h1111, 32'd0);
    send_op(OP_EDIT,   16'h0005, 16'h0000, 32'd9);
    send_op(OP_REMOVE, 16'h0005, 16'h0000, 32'd0);
    send_op(OP_ADD,    16'h0000, 16'hFFFF, 32'h0000_0000);
    send_op(OP_ADD,    16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    send_op(OP_ADD,    16'h1234, 16'h5A5A, 32'hFFFF_FFFF);
    // equal priority: the larger id wins
    send_op(OP_EXEC,   16'h0000, 16'h0000, 32'd0);
    // add of an existing id replaces it in place
    send_op(OP_ADD,    16'h0000, 16'hAAAA, 32'd7);
    send_op(OP_EDIT,   16'h0000, 16'h3333, 32'hFFFF_FFFF);
    send_op(OP_EXEC,   16'h0000, 16'h0000, 32'd0);
    send_op(OP_EXEC,   16'h0000, 16'h0000, 32'd0);
    send_op(OP_EXEC,   16'h0000, 16'h0000, 32'd0);
    send_op(OP_ADD,    16'h0007, 16'h0101, 32'h8000_0000);
    send_op(OP_REMOVE, 16'h0007, 16'h0000, 32'd0);
    send_op(OP_REMOVE, 16'h0007, 16'h0000, 32'd0);
    send_op(OP_EDIT,   16'h0007, 16'h0000, 32'd1);

    // random phases: sender/receiver idling swapped, then none
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 22 : (ph == 1) ? 55 : 0;
      rx_idle = (ph == 0) ? 55 : (ph == 1) ? 22 : 0;
      // long receiver hold-off so the block backs up and stalls its input
      if (ph == 0) hold_req <= 400;
      // send add-heavy transactions, then drain-heavy ones
      for (int n = 0; n < 110; n++) send_random(1'b1);
      for (int n = 0; n < 68; n++) send_random(1'b0);
    end
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (CAPACITY + 16) @(posedge clk);
    $display("ran %0d transactions through add, edit, remove and exec-top,", items_sent);
    $display("including full-table, tie-break and replace cases; %0d results", results_seen);
    if (errors == 0) begin
      $display("keyed_priority_task_queue_top test passed");
    end else begin
      $display("keyed_priority_task_queue_top test failed");
    end
    $finish;
  end

endmodule
